// File: rtl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared widths, types and register indexes for the polyline length block.
// ----------------------------------------------------------------------------
package plb_pkg;

    localparam int FRACTION_BITS = 4;

    localparam int COORD_W  = 16;
    localparam int LEN_W    = 32;
    localparam int BOUND_W  = 21;
    localparam int MAG_W    = COORD_W;                       // |a - b| of two coordinates
    localparam int SQS_W    = 2 * MAG_W + 1;                 // dx^2 + dy^2
    localparam int RAD_IN_W = SQS_W + 2 * FRACTION_BITS;     // scaled radicand
    localparam int ROOT_W   = (RAD_IN_W + 1) / 2;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int CNT_W    = $clog2(ROOT_W + 1);

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_REF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MAX_Y = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [MAG_W-1:0]   t_mag;
    typedef logic        [ROOT_W-1:0]  t_root;
    typedef logic        [LEN_W-1:0]   t_len;

    // absolute difference of two signed coordinates
    function automatic t_mag abs_diff(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        begin
            d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            m = d[COORD_W] ? (~d + 1'b1) : d;
            return m[MAG_W-1:0];
        end
    endfunction

endpackage

// File: rtl/plb_if.sv
// ----------------------------------------------------------------------------
// plb interfaces
// Point, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface plb_pt_if;
    import plb_pkg::*;
    logic   valid;
    logic   ready;
    logic   start_req;
    t_coord px;
    t_coord py;
    modport source (output valid, output start_req, output px, output py, input ready);
    modport sink   (input valid, input start_req, input px, input py, output ready);
endinterface

interface plb_res_if;
    import plb_pkg::*;
    logic                 valid;
    logic                 ready;
    t_len                 length_so_far;
    logic                 length_saturated;
    t_coord               box_min_x;
    t_coord               box_min_y;
    t_coord               box_max_x;
    t_coord               box_max_y;
    logic [BOUND_W-1:0]   distance_bound;
    modport source (output valid, output length_so_far, output length_saturated,
                    output box_min_x, output box_min_y, output box_max_x,
                    output box_max_y, output distance_bound, input ready);
    modport sink   (input valid, input length_so_far, input length_saturated,
                    input box_min_x, input box_min_y, input box_max_x,
                    input box_max_y, input distance_bound, output ready);
endinterface

interface plb_cfg_if;
    import plb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/plb_sqrt.sv
// ----------------------------------------------------------------------------
// plb_sqrt
// Restoring integer square root, one result bit per cycle (floor).
// ----------------------------------------------------------------------------
module plb_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [plb_pkg::RAD_IN_W-1:0] i_rad,
    output logic                    o_done,
    output plb_pkg::t_root          o_root
);
    import plb_pkg::*;

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    t_root             r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+1:0] w_rem_sh;
    logic [ROOT_W+1:0] w_trial;
    logic              w_fit;

    // bring down the next two radicand bits and try a one
    assign w_rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rad  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= RAD_W'(i_rad);
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= r_rad << 2;
                r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], w_fit};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/polyline_length_and_bounds.sv
// ----------------------------------------------------------------------------
// polyline_length_and_bounds
// Running arc length, bounding box and diagonal bound of a polyline.
// ----------------------------------------------------------------------------
// Points arrive on i_pt (start_req, px, py); one result per point leaves on
// o_res. Reference box registers are written over i_cfg (index 0 enables the
// reference, 1..4 give its min x/y and max x/y); writes are always accepted
// and must happen while no point is in flight.
// A point is taken only when the sequencer is idle. Both square roots (segment
// length, then box diagonal) run on one bit-per-cycle root unit. Each pass
// squares both magnitudes in turn on a shared 16x16 squarer (S_SQA, S_SQB),
// launches the root (S_START) and waits in S_WAIT for its 21 root steps.
// A point that starts a curve skips the segment root and runs only the
// diagonal pass; any other point runs both passes. The sequencer returns to
// idle once the result is loaded into the output register. A stalled result
// holds; the next point is still taken while it waits, and the following
// result waits behind it in S_DONE, delaying that point.
// Reset clears the configuration, the running length, the box and the record
// of earlier points, so the first point after reset opens a curve.
// ----------------------------------------------------------------------------
module polyline_length_and_bounds (
    input  logic i_clk,
    input  logic i_rst_n,
    plb_pt_if.sink    i_pt,
    plb_cfg_if.sink   i_cfg,
    plb_res_if.source o_res
);
    import plb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQA   = 3'd1;
    localparam logic [2:0] S_SQB   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_PREP  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic       r_phase;          // 0: segment length, 1: box diagonal

    // configuration
    logic   r_use_ref;
    t_coord r_ref_min_x, r_ref_min_y, r_ref_max_x, r_ref_max_y;

    // curve state
    t_len   r_len;
    logic   r_clip;
    logic   r_has_point;
    t_coord r_last_x, r_last_y;
    t_coord r_low_x, r_low_y, r_high_x, r_high_y;

    // arithmetic
    t_mag             r_ma, r_mb;
    logic [SQS_W-1:0] r_acc;
    logic [BOUND_W-1:0] r_bound;

    // output register
    logic               r_out_valid;
    t_len               r_out_len;
    logic               r_out_sat;
    t_coord             r_out_min_x, r_out_min_y, r_out_max_x, r_out_max_y;
    logic [BOUND_W-1:0] r_out_bound;

    logic               w_accept;
    logic               w_first;
    logic [2*MAG_W-1:0] w_prod;
    t_mag               w_mul;
    logic               w_sq_start;
    logic               w_sq_done;
    t_root              w_root;
    logic [LEN_W:0]     w_sum;
    logic               w_out_free;
    t_coord             w_mnx, w_mny, w_mxx, w_mxy;

    assign i_pt.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_pt.valid && i_pt.ready;
    assign w_first     = i_pt.start_req || !r_has_point;
    assign w_out_free  = !r_out_valid || o_res.ready;

    // one squarer, fed by each magnitude in turn
    assign w_mul  = (r_state == S_SQA) ? r_ma : r_mb;
    assign w_prod = w_mul * w_mul;

    assign w_sum  = {1'b0, r_len} + (LEN_W + 1)'(w_root);

    // merge the reference box into the current one when enabled
    always_comb begin
        w_mnx = r_low_x;
        w_mny = r_low_y;
        w_mxx = r_high_x;
        w_mxy = r_high_y;
        if (r_use_ref) begin
            if (r_ref_min_x < w_mnx) w_mnx = r_ref_min_x;
            if (r_ref_min_y < w_mny) w_mny = r_ref_min_y;
            if (r_ref_max_x > w_mxx) w_mxx = r_ref_max_x;
            if (r_ref_max_y > w_mxy) w_mxy = r_ref_max_y;
        end
    end

    assign w_sq_start = (r_state == S_START);

    plb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (RAD_IN_W'(r_acc) << (2 * FRACTION_BITS)),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_ref   <= 1'b0;
            r_ref_min_x <= '0;
            r_ref_min_y <= '0;
            r_ref_max_x <= '0;
            r_ref_max_y <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_USE_REF:   r_use_ref   <= i_cfg.data[0];
                CFG_REF_MIN_X: r_ref_min_x <= i_cfg.data;
                CFG_REF_MIN_Y: r_ref_min_y <= i_cfg.data;
                CFG_REF_MAX_X: r_ref_max_x <= i_cfg.data;
                CFG_REF_MAX_Y: r_ref_max_y <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // sequencer and curve state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_len       <= '0;
            r_clip      <= 1'b0;
            r_has_point <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_low_x     <= '0;
            r_low_y     <= '0;
            r_high_x    <= '0;
            r_high_y    <= '0;
            r_ma        <= '0;
            r_mb        <= '0;
            r_acc       <= '0;
            r_bound     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last_x    <= i_pt.px;
                        r_last_y    <= i_pt.py;
                        r_has_point <= 1'b1;
                        r_ma        <= abs_diff(i_pt.px, r_last_x);
                        r_mb        <= abs_diff(i_pt.py, r_last_y);
                        if (w_first) begin
                            r_len    <= '0;
                            r_clip   <= 1'b0;
                            r_low_x  <= i_pt.px;
                            r_high_x <= i_pt.px;
                            r_low_y  <= i_pt.py;
                            r_high_y <= i_pt.py;
                            r_state  <= S_PREP;
                        end else begin
                            if (i_pt.px < r_low_x)  r_low_x  <= i_pt.px;
                            if (i_pt.px > r_high_x) r_high_x <= i_pt.px;
                            if (i_pt.py < r_low_y)  r_low_y  <= i_pt.py;
                            if (i_pt.py > r_high_y) r_high_y <= i_pt.py;
                            r_phase <= 1'b0;
                            r_state <= S_SQA;
                        end
                    end
                end
                S_SQA: begin
                    r_acc   <= SQS_W'(w_prod);
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_acc   <= r_acc + SQS_W'(w_prod);
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_sq_done) begin
                        if (!r_phase) begin
                            // saturate the running length
                            if (w_sum[LEN_W]) begin
                                r_len  <= '1;
                                r_clip <= 1'b1;
                            end else begin
                                r_len <= w_sum[LEN_W-1:0];
                            end
                            r_state <= S_PREP;
                        end else begin
                            r_bound <= BOUND_W'(w_root);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_PREP: begin
                    r_ma    <= abs_diff(w_mxx, w_mnx);
                    r_mb    <= abs_diff(w_mxy, w_mny);
                    r_phase <= 1'b1;
                    r_state <= S_SQA;
                end
                S_DONE: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: load when it is empty or its result is being transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_len   <= r_len;
            r_out_sat   <= r_clip;
            r_out_min_x <= r_low_x;
            r_out_min_y <= r_low_y;
            r_out_max_x <= r_high_x;
            r_out_max_y <= r_high_y;
            r_out_bound <= r_bound;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.length_so_far    = r_out_len;
    assign o_res.length_saturated = r_out_sat;
    assign o_res.box_min_x        = r_out_min_x;
    assign o_res.box_min_y        = r_out_min_y;
    assign o_res.box_max_x        = r_out_max_x;
    assign o_res.box_max_y        = r_out_max_y;
    assign o_res.distance_bound   = r_out_bound;

endmodule

// File: dv/polyline_length_and_bounds_tb.sv
// ----------------------------------------------------------------------------
// polyline_length_and_bounds_tb
// Streams polyline points into the block and checks every result against a
// cycle-free predictor of the running length, box and diagonal bound. Covers
// curve starts, extreme coordinates, reference boxes (normal and inverted),
// long far-corner bounces and random curves, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module polyline_length_and_bounds_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plb_pkg::*;

    typedef struct {
        t_len               length;
        logic               clipped;
        t_coord             min_x;
        t_coord             min_y;
        t_coord             max_x;
        t_coord             max_y;
        logic [BOUND_W-1:0] bound;
    } t_curve_summary;

    logic clk;
    logic rst_n;
    bit   gaps_on;
    int   mismatches;

    t_curve_summary expected_summaries[$];

    // predictor state and its copy of the registers
    t_len   run_len;
    logic   clipped;
    logic   seen_point;
    t_coord prev_x, prev_y;
    t_coord lo_x, lo_y, hi_x, hi_y;
    logic   ref_on;
    t_coord ref_lo_x, ref_lo_y, ref_hi_x, ref_hi_y;

    plb_pt_if  pt ();
    plb_cfg_if cfg ();
    plb_res_if res ();

    polyline_length_and_bounds i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pt    (pt),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 23; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic longint unsigned scaled_hypot(input t_coord ax, input t_coord ay,
                                                      input t_coord bx, input t_coord by);
        longint          dx;
        longint          dy;
        longint unsigned sq;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        sq = dx * dx + dy * dy;
        return floor_root(sq << (2 * FRACTION_BITS));
    endfunction

    function automatic void predict_point(input logic start, input t_coord x, input t_coord y);
        t_curve_summary  s;
        longint unsigned sum;
        longint unsigned diag;
        t_coord          mnx, mny, mxx, mxy;
        if (start || !seen_point) begin
            run_len = '0;
            clipped = 1'b0;
            lo_x = x;
            hi_x = x;
            lo_y = y;
            hi_y = y;
        end else begin
            sum = run_len + scaled_hypot(prev_x, prev_y, x, y);
            if (sum > 64'hFFFF_FFFF) begin
                run_len = '1;
                clipped = 1'b1;
            end else begin
                run_len = sum[LEN_W-1:0];
            end
            if (x < lo_x) lo_x = x;
            if (y < lo_y) lo_y = y;
            if (x > hi_x) hi_x = x;
            if (y > hi_y) hi_y = y;
        end
        prev_x = x;
        prev_y = y;
        seen_point = 1'b1;

        mnx = lo_x;
        mny = lo_y;
        mxx = hi_x;
        mxy = hi_y;
        if (ref_on) begin
            if (ref_lo_x < mnx) mnx = ref_lo_x;
            if (ref_lo_y < mny) mny = ref_lo_y;
            if (ref_hi_x > mxx) mxx = ref_hi_x;
            if (ref_hi_y > mxy) mxy = ref_hi_y;
        end
        diag = scaled_hypot(mnx, mny, mxx, mxy);

        s.length  = run_len;
        s.clipped = clipped;
        s.min_x   = lo_x;
        s.min_y   = lo_y;
        s.max_x   = hi_x;
        s.max_y   = hi_y;
        s.bound   = diag[BOUND_W-1:0];
        expected_summaries = {expected_summaries, s};
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        if (mismatches < 50)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin
        t_curve_summary want;
        if (rst_n && res.valid && res.ready) begin
            if (expected_summaries.size() == 0) begin
                flag_mismatch("unexpected result", res.length_so_far, 0);
            end else begin
                want = expected_summaries.pop_front();
                if (res.length_so_far !== want.length)
                    flag_mismatch("length_so_far", res.length_so_far, want.length);
                if (res.length_saturated !== want.clipped)
                    flag_mismatch("length_saturated", res.length_saturated, want.clipped);
                if (res.box_min_x !== want.min_x)
                    flag_mismatch("box_min_x", 16'(res.box_min_x), 16'(want.min_x));
                if (res.box_min_y !== want.min_y)
                    flag_mismatch("box_min_y", 16'(res.box_min_y), 16'(want.min_y));
                if (res.box_max_x !== want.max_x)
                    flag_mismatch("box_max_x", 16'(res.box_max_x), 16'(want.max_x));
                if (res.box_max_y !== want.max_y)
                    flag_mismatch("box_max_y", 16'(res.box_max_y), 16'(want.max_y));
                if (res.distance_bound !== want.bound)
                    flag_mismatch("distance_bound", res.distance_bound, want.bound);
            end
        end
    end

    // result sink: stall in random bursts while gaps are enabled
    initial begin
        res.ready = 1'b1;
        forever begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                res.ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            res.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // drivers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------
    task automatic send_point(input logic start, input t_coord x, input t_coord y);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            pt.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        pt.valid     = 1'b1;
        pt.start_req = start;
        pt.px        = x;
        pt.py        = y;
        do @(posedge clk); while (!pt.ready);
        predict_point(start, x, y);
        @(negedge clk);
        pt.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            CFG_USE_REF:   ref_on   = value[0];
            CFG_REF_MIN_X: ref_lo_x = value;
            CFG_REF_MIN_Y: ref_lo_y = value;
            CFG_REF_MAX_X: ref_hi_x = value;
            CFG_REF_MAX_Y: ref_hi_y = value;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic wait_all_results();
        while (expected_summaries.size() != 0) @(negedge clk);
    endtask

    task automatic load_reference(input logic on, input t_coord mnx, input t_coord mny,
                                  input t_coord mxx, input t_coord mxy);
        wait_all_results();
        write_reg(CFG_USE_REF, {15'd0, on});
        write_reg(CFG_REF_MIN_X, mnx);
        write_reg(CFG_REF_MIN_Y, mny);
        write_reg(CFG_REF_MAX_X, mxx);
        write_reg(CFG_REF_MAX_Y, mxy);
    endtask

    function automatic t_coord pick_coord(input t_coord near);
        t_coord c;
        case ($urandom_range(0, 9))
            0:       c = 16'sh8000;
            1:       c = 16'sh7FFF;
            2, 3:    c = t_coord'($urandom);
            4, 5, 6: c = near + t_coord'($urandom_range(0, 64)) - 16'sd32;
            default: c = near + t_coord'($urandom_range(0, 4096)) - 16'sd2048;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_first_point_without_start();
        // the very first point opens a curve even with start_req low
        send_point(1'b0, 16'sd100, -16'sd200);
        send_point(1'b0, 16'sd400, 16'sd200);
        send_point(1'b0, -16'sd50, 16'sd0);
    endtask

    task automatic test_extreme_points();
        send_point(1'b1, 16'sh8000, 16'sh8000);
        send_point(1'b0, 16'sh7FFF, 16'sh7FFF);
        send_point(1'b0, 16'sh8000, 16'sh7FFF);
        send_point(1'b0, 16'sh7FFF, 16'sh8000);
        send_point(1'b0, 16'sd0, 16'sd0);
        send_point(1'b1, 16'sh7FFF, 16'sh7FFF);
        send_point(1'b0, 16'sh7FFF, 16'sh7FFF);
        send_point(1'b1, -16'sd1, -16'sd1);
    endtask

    task automatic test_reference_box();
        load_reference(1'b1, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_point(1'b1, 16'sd5, 16'sd5);
        send_point(1'b0, 16'sd0, -16'sd7);
        // inverted reference: min above max, merged as given
        load_reference(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        send_point(1'b1, 16'sd300, -16'sd300);
        send_point(1'b0, -16'sd300, 16'sd300);
        load_reference(1'b1, 16'sd100, -16'sd40, -16'sd100, 16'sd40);
        send_point(1'b1, 16'sd0, 16'sd0);
        load_reference(1'b0, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_point(1'b0, 16'sd20, 16'sd30);
    endtask

    task automatic test_hold_mid_curve();
        send_point(1'b1, 16'sd1000, -16'sd1000);
        send_point(1'b0, 16'sd1003, -16'sd996);
        // hold the sender until the block has drained, then resume the curve
        wait_all_results();
        send_point(1'b0, -16'sd7000, 16'sd12000);
        send_point(1'b0, 16'sd1000, -16'sd1000);
    endtask

    task automatic test_long_bounces();
        t_coord j;
        load_reference(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_point(1'b1, 16'sh8000, 16'sh8000);
        // bounce between far corners so the length grows in the largest steps
        for (int n = 0; n < 250; n++) begin
            j = t_coord'($urandom_range(0, 3));
            if (n % 2 == 0)
                send_point(1'b0, 16'sh7FFF - j, 16'sh7FFF - j);
            else
                send_point(1'b0, 16'sh8000 + j, 16'sh8000 + j);
        end
        send_point(1'b0, 16'sd0, 16'sd0);
        send_point(1'b1, 16'sd0, 16'sd0);
        send_point(1'b0, 16'sd3, 16'sd4);
    endtask

    task automatic test_random_curves();
        int     sent;
        int     span;
        logic   start;
        t_coord x, y;
        x = 0;
        y = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: load_reference(1'b0, t_coord'($urandom), t_coord'($urandom),
                                  t_coord'($urandom), t_coord'($urandom));
                1: load_reference(1'b1, -t_coord'($urandom_range(0, 20000)),
                                  -t_coord'($urandom_range(0, 20000)),
                                  t_coord'($urandom_range(0, 20000)),
                                  t_coord'($urandom_range(0, 20000)));
                2: load_reference(1'b1, t_coord'($urandom_range(0, 32767)),
                                  t_coord'($urandom_range(0, 32767)),
                                  -t_coord'($urandom_range(0, 32767)),
                                  -t_coord'($urandom_range(0, 32767)));
                default: load_reference(1'b1, t_coord'($urandom), t_coord'($urandom),
                                        t_coord'($urandom), t_coord'($urandom));
            endcase
            sent = 0;
            while (sent < 300) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                span    = $urandom_range(1, 40);
                // mostly well-formed curves; now and then a curve with no start
                for (int k = 0; k < span; k++) begin
                    if (k == 0)
                        start = ($urandom_range(0, 7) != 0);
                    else
                        start = ($urandom_range(0, 29) == 0);
                    x = pick_coord(x);
                    y = pick_coord(y);
                    send_point(start, x, y);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_back_to_back();
        t_coord x, y;
        gaps_on = 1'b0;
        x = 0;
        y = 0;
        for (int k = 0; k < 100; k++) begin
            x = pick_coord(x);
            y = pick_coord(y);
            send_point(k % 17 == 0, x, y);
        end
    endtask

    initial begin
        mismatches   = 0;
        gaps_on      = 1'b1;
        rst_n        = 1'b0;
        pt.valid     = 1'b0;
        pt.start_req = 1'b0;
        pt.px        = '0;
        pt.py        = '0;
        cfg.valid    = 1'b0;
        cfg.index    = CFG_USE_REF;
        cfg.data     = '0;
        run_len      = '0;
        clipped      = 1'b0;
        seen_point   = 1'b0;
        prev_x       = '0;
        prev_y       = '0;
        lo_x         = '0;
        lo_y         = '0;
        hi_x         = '0;
        hi_y         = '0;
        ref_on       = 1'b0;
        ref_lo_x     = '0;
        ref_lo_y     = '0;
        ref_hi_x     = '0;
        ref_hi_y     = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_first_point_without_start();
        test_extreme_points();
        test_reference_box();
        test_hold_mid_curve();
        test_long_bounces();
        test_random_curves();
        test_back_to_back();

        wait_all_results();
        repeat (120) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/plb_pkg.sv
rtl/plb_if.sv
rtl/plb_sqrt.sv
rtl/polyline_length_and_bounds.sv
dv/polyline_length_and_bounds_tb.sv
